>>> hdl/bcs_pkg.sv
package bcs_pkg;

    // fixed processing constants
    localparam int unsigned TICK_MS         = 1;
    localparam int unsigned TRIGGER_HOLD_MS = 100;
    localparam int unsigned GAP_MS          = 100;
    localparam int unsigned SMOOTH_MULT     = 7;
    localparam int unsigned SMOOTH_SHIFT    = 3;
    localparam int unsigned VOLUME_SCALE    = 256;
    localparam int unsigned VOLUME_FRAC     = 18;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_MS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_MS          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ARM_MS         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_DROP   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESSURE_LIMIT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_ENABLE     = 3'd6;

    typedef struct packed {
        logic [12:0]        cycle_ms;
        logic [12:0]        on_ms;
        logic [12:0]        arm_ms;
        logic               trigger_enable;
        logic [14:0]        trigger_drop;
        logic signed [15:0] pressure_limit;
        logic               run_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] flow_sample;
        logic signed [15:0] pressure_sample;
    } sample_t;

    typedef struct packed {
        logic [12:0]        cycle_time;
        logic signed [15:0] smoothed_pressure;
        logic               over_pressure;
        logic               patient_started;
        logic               breath_done;
        logic [15:0]        breath_volume;
        logic signed [15:0] breath_peak;
    } result_t;

endpackage

>>> hdl/bcs_cfg.sv
module bcs_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [bcs_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]      wr_data,
    output bcs_pkg::cfg_t                       cfg
);

    bcs_pkg::cfg_t cfg_reg;
    bcs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bcs_pkg::REG_CYCLE_MS:       cfg_next.cycle_ms       = wr_data[12:0];
                bcs_pkg::REG_ON_MS:          cfg_next.on_ms          = wr_data[12:0];
                bcs_pkg::REG_ARM_MS:         cfg_next.arm_ms         = wr_data[12:0];
                bcs_pkg::REG_TRIGGER_ENABLE: cfg_next.trigger_enable = wr_data[0];
                bcs_pkg::REG_TRIGGER_DROP:   cfg_next.trigger_drop   = wr_data[14:0];
                bcs_pkg::REG_PRESSURE_LIMIT: cfg_next.pressure_limit = signed'(wr_data);
                bcs_pkg::REG_RUN_ENABLE:     cfg_next.run_enable     = wr_data[0];
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_ms       <= 13'd3000;
            cfg_reg.on_ms          <= 13'd1000;
            cfg_reg.arm_ms         <= 13'd1500;
            cfg_reg.trigger_enable <= 1'b0;
            cfg_reg.trigger_drop   <= 15'd0;
            cfg_reg.pressure_limit <= 16'sd32767;
            cfg_reg.run_enable     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/bcs_core.sv
module bcs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  bcs_pkg::sample_t    sample,
    input  bcs_pkg::cfg_t       cfg,
    output bcs_pkg::result_t    result
);

    localparam logic signed [25:0] MULT_S     = 26'(bcs_pkg::SMOOTH_MULT);
    localparam logic signed [25:0] S16_MAX_26 = 26'sd32767;
    localparam logic signed [25:0] S16_MIN_26 = -26'sd32768;
    localparam logic signed [49:0] SCALE_S    = 50'(bcs_pkg::VOLUME_SCALE);
    localparam logic signed [49:0] U16_MAX_50 = 50'sd65535;

    logic [13:0]        time_reg, time_next;
    logic               reported_reg, reported_next;
    logic signed [15:0] peak_reg, peak_next;
    logic signed [15:0] peep_reg, peep_next;
    logic signed [15:0] filt_reg, filt_next;
    logic signed [31:0] vol_reg, vol_next;
    logic [15:0]        elapsed_reg, elapsed_next;

    logic [13:0]        tc_inc;
    logic [13:0]        report_time;
    logic signed [25:0] acc;
    logic signed [25:0] acc_sh;
    logic signed [32:0] vsum;
    logic signed [16:0] trig_level;
    logic [16:0]        elapsed_sum;
    logic signed [49:0] scaled;
    logic               fire;

    always_comb
    begin
        tc_inc        = time_reg + 14'(bcs_pkg::TICK_MS);
        report_time   = {1'b0, cfg.on_ms} + 14'(bcs_pkg::GAP_MS);
        time_next     = tc_inc;
        reported_next = reported_reg;
        peak_next     = peak_reg;
        peep_next     = peep_reg;
        filt_next     = filt_reg;
        vol_next      = vol_reg;
        elapsed_next  = elapsed_reg;
        acc           = '0;
        acc_sh        = '0;
        vsum          = '0;
        trig_level    = '0;
        elapsed_sum   = '0;
        scaled        = '0;
        fire          = 1'b0;
        result        = '0;

        // cycle wrap
        if (tc_inc >= {1'b0, cfg.cycle_ms})
        begin
            time_next     = '0;
            reported_next = 1'b0;
            peak_next     = '0;
        end

        if (cfg.run_enable)
        begin
            // low-pass, floored shift then saturate
            acc    = 26'(sample.pressure_sample) + 26'(filt_reg) * MULT_S;
            acc_sh = acc >>> bcs_pkg::SMOOTH_SHIFT;
            if (acc_sh > S16_MAX_26)
                filt_next = 16'sd32767;
            else if (acc_sh < S16_MIN_26)
                filt_next = -16'sd32768;
            else
                filt_next = acc_sh[15:0];

            result.over_pressure = (filt_next > cfg.pressure_limit);
            if (filt_next > peak_next)
                peak_next = filt_next;
            if (time_next == '0)
                peep_next = filt_next;

            // saturating volume sum
            vsum = 33'(vol_reg) + 33'(sample.flow_sample);
            if (vsum[32] != vsum[31])
                vol_next = vsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                vol_next = vsum[31:0];

            // patient trigger
            if (time_next >= {1'b0, cfg.arm_ms})
            begin
                trig_level = 17'(peep_next) - signed'({2'b00, cfg.trigger_drop});
                if (cfg.trigger_enable && (17'(sample.pressure_sample) < trig_level))
                begin
                    elapsed_sum  = {1'b0, elapsed_reg} + 17'(bcs_pkg::TICK_MS);
                    elapsed_next = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
                    fire         = (elapsed_next >= 16'(bcs_pkg::TRIGGER_HOLD_MS));
                end
                else
                begin
                    elapsed_next = '0;
                end
                if (fire)
                begin
                    time_next              = '0;
                    result.patient_started = 1'b1;
                end
            end

            // end-of-breath report
            if ((time_next > report_time) && !reported_next)
            begin
                scaled = (50'(vol_next) * SCALE_S) >>> bcs_pkg::VOLUME_FRAC;
                if (scaled < 50'sd0)
                    result.breath_volume = '0;
                else if (scaled > U16_MAX_50)
                    result.breath_volume = 16'hFFFF;
                else
                    result.breath_volume = scaled[15:0];
                result.breath_done = 1'b1;
                result.breath_peak = peak_next;
                reported_next      = 1'b1;
                vol_next           = '0;
            end
        end

        result.cycle_time        = time_next[12:0];
        result.smoothed_pressure = filt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            reported_reg <= 1'b0;
            peak_reg     <= '0;
            peep_reg     <= '0;
            filt_reg     <= '0;
            vol_reg      <= '0;
            elapsed_reg  <= '0;
        end
        else if (advance)
        begin
            time_reg     <= time_next;
            reported_reg <= reported_next;
            peak_reg     <= peak_next;
            peep_reg     <= peep_next;
            filt_reg     <= filt_next;
            vol_reg      <= vol_next;
            elapsed_reg  <= elapsed_next;
        end
    end

endmodule

>>> hdl/breath_cycle_sequencer.sv
// an accepted sample item passes through the sample register and the result register
// throughput: one item per cycle while result_stall is low; the breath state updates
// in a single pass between the sample register and the result register
// reset (rst_n, async active low): config registers to their defaults, breath state
// cleared, both pipeline valids low
module breath_cycle_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  bcs_pkg::sample_t                  sample,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output bcs_pkg::result_t                  result,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bcs_pkg::cfg_t     cfg;
    bcs_pkg::sample_t  sample_reg;
    bcs_pkg::result_t  result_reg;
    bcs_pkg::result_t  core_result;

    logic sample_valid_reg, sample_valid_next;
    logic result_valid_reg, result_valid_next;
    logic take;     // sample item accepted this cycle
    logic advance;  // held sample moves through the core into the result register

    // config writes are always taken
    assign cfg_ready = 1'b1;

    bcs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // result register frees up when empty or when its item is taken this cycle
    assign advance      = sample_valid_reg && (!result_valid_reg || !result_stall);
    // sample register is free when empty or when it moves on this cycle
    assign sample_stall = sample_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;

    always_comb
    begin
        sample_valid_next = take || (sample_valid_reg && !advance);
        result_valid_next = advance || (result_valid_reg && result_stall);
    end

    // breath state lives in the core and only moves on advance
    bcs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (sample_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sample_valid_reg <= sample_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            sample_reg <= sample;
        if (advance)
            result_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
